[src/keyframe_color_interpolator_top_assert.svh]
`ifndef KEYFRAME_COLOR_INTERPOLATOR_TOP_ASSERT_SVH
`define KEYFRAME_COLOR_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define KCI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset
`define KCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/kci_pkg.sv]
package kci_pkg;

  localparam int unsigned Q_BITS    = 12;
  localparam int unsigned WT_W      = Q_BITS + 1;
  localparam int unsigned DIV_STEPS = Q_BITS + 1;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [WT_W-1:0] Q_ONE    = WT_W'(13'h1000);
  localparam logic [7:0]      END_MARK = 8'hFF;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } kci_colour_t;

  typedef struct packed {
    kci_colour_t colour;
    logic [7:0]  dur;
  } kci_key_t;

  typedef struct packed {
    logic       go;
    logic [7:0] span_left;
    logic [7:0] dur;
  } kci_div_req_t;

  typedef struct packed {
    logic            done;
    logic [WT_W-1:0] weight;
  } kci_div_res_t;

endpackage

[src/kci_key_cell.sv]
module kci_key_cell import kci_pkg::*; (
  input  logic     clk,
  input  logic     wr_en,
  input  kci_key_t wr_key,
  input  logic     shift_en,
  input  kci_key_t nbr_key,
  output kci_key_t key_q
);

  kci_key_t key_r;
  kci_key_t key_nxt;

  // rotate towards slot 0 while walking, otherwise take a write
  always_comb begin
    key_nxt = key_r;
    if (shift_en) begin
      key_nxt = nbr_key;
    end else if (wr_en) begin
      key_nxt = wr_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;

endmodule

[src/kci_divider.sv]
module kci_divider import kci_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  kci_div_req_t req,
  output kci_div_res_t res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [8:0]        rem_r, rem_nxt;
  logic [7:0]        dur_r, dur_nxt;
  logic [WT_W-1:0]   quo_r, quo_nxt;

  logic [8:0] trial;
  logic       fits;
  logic       last;

  // first step takes the integer bit, the rest one fraction bit each
  assign trial = (cnt_r == '0) ? rem_r : {rem_r[7:0], 1'b0};
  assign fits  = (trial >= {1'b0, dur_r});
  assign last  = (cnt_r == DCNT_W'(DIV_STEPS - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dur_nxt  = dur_r;
    quo_nxt  = quo_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, req.span_left};
      dur_nxt  = req.dur;
    end else if (busy_r) begin
      rem_nxt = fits ? (trial - {1'b0, dur_r}) : trial;
      quo_nxt = {quo_r[WT_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dur_r <= dur_nxt;
    quo_r <= quo_nxt;
  end

  assign res.done   = done_r;
  assign res.weight = quo_r;

endmodule

[src/keyframe_color_interpolator_top.sv]
// Write beat: busy stays low. Evaluate beat: busy while the walk goes once round the
// keyframe ring, then, for a blend, through the bit-serial division (start, quotient steps,
// done) and the per-colour blending of red, green and blue; out_strobe then rises with the
// result (straight after the walk for a held end colour), busy falls with it, and the next
// beat can be taken while out_strobe is high. The keyframe ring walks one slot per cycle.
// Reset (rst_n low, synchronous) clears control only; keyframes are undefined until written.
module keyframe_color_interpolator_top import kci_pkg::*; #(
  parameter int unsigned KEY_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [3:0]  in_entry_index,
  input  logic [7:0]  in_key_red,
  input  logic [7:0]  in_key_green,
  input  logic [7:0]  in_key_blue,
  input  logic [7:0]  in_key_duration,
  input  logic [15:0] in_time_step,
  output logic        out_strobe,
  output logic [7:0]  out_color_red,
  output logic [7:0]  out_color_green,
  output logic [7:0]  out_color_blue,
  output logic        out_held_at_end
);

  localparam int unsigned CW = $clog2(KEY_COUNT);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_MIX  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    COMP_RED,
    COMP_GREEN,
    COMP_BLUE
  } comp_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   walk_cnt_r, walk_cnt_nxt;
  logic            found_r, found_nxt;
  logic            span_hit_r, span_hit_nxt;
  logic            div_go_r, div_go_nxt;
  comp_t           comp_r, comp_nxt;
  logic            out_strobe_r, out_strobe_nxt;

  logic [15:0]     sum_r, sum_nxt;
  logic [15:0]     step_r, step_nxt;
  kci_colour_t     cur_r, cur_nxt;
  kci_colour_t     nxt_r, nxt_nxt;
  logic [7:0]      span_r, span_nxt;
  logic [7:0]      sdur_r, sdur_nxt;
  logic [WT_W-1:0] weight_r, weight_nxt;
  kci_colour_t     out_col_r, out_col_nxt;
  logic            out_held_r, out_held_nxt;

  kci_key_t        ring_q [KEY_COUNT];
  kci_key_t        wr_key;
  logic            wr_beat;
  logic            shift_en;

  kci_key_t        head;
  kci_key_t        second;
  logic            last;
  logic [16:0]     run_sum;
  logic [16:0]     span_wide;
  logic            hit_span;
  logic            hit_end;
  kci_colour_t     end_col;

  logic [WT_W-1:0] inv_w;
  logic [7:0]      cur_c;
  logic [7:0]      nxt_c;
  logic [20:0]     prod_nxt;
  logic [20:0]     prod_cur;
  logic [20:0]     mix_acc;
  logic [7:0]      blend;

  kci_div_req_t    div_req;
  kci_div_res_t    div_res;

  assign wr_key.colour.red   = in_key_red;
  assign wr_key.colour.green = in_key_green;
  assign wr_key.colour.blue  = in_key_blue;
  assign wr_key.dur          = in_key_duration;

  assign wr_beat  = (state_r == ST_IDLE) && start && (in_func == FUNC_WRITE);
  assign shift_en = (state_r == ST_WALK);

  // slot i hands its keyframe to slot i-1; slot 0 always shows the key under test
  for (genvar i = 0; i < KEY_COUNT; i++) begin : g_cell
    kci_key_cell u_cell (
      .clk      (clk),
      .wr_en    (wr_beat && (32'(in_entry_index) == 32'(i))),
      .wr_key   (wr_key),
      .shift_en (shift_en),
      .nbr_key  (ring_q[(i + 1) % KEY_COUNT]),
      .key_q    (ring_q[i])
    );
  end

  assign head      = ring_q[0];
  assign second    = ring_q[1];
  assign last      = (walk_cnt_r == CW'(KEY_COUNT - 1));
  assign run_sum   = {1'b0, sum_r} + {9'd0, head.dur};
  assign span_wide = run_sum - {1'b0, step_r};
  assign hit_span  = !found_r && ({1'b0, step_r} < run_sum) && (head.dur != '0);
  assign hit_end   = !found_r && !hit_span && (last || (second.dur == END_MARK));
  assign end_col   = last ? head.colour : second.colour;

  assign div_req.go        = div_go_r;
  assign div_req.span_left = span_r;
  assign div_req.dur       = sdur_r;

  kci_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // one colour component per cycle
  always_comb begin
    case (comp_r)
      COMP_RED: begin
        cur_c = cur_r.red;
        nxt_c = nxt_r.red;
      end
      COMP_GREEN: begin
        cur_c = cur_r.green;
        nxt_c = nxt_r.green;
      end
      COMP_BLUE: begin
        cur_c = cur_r.blue;
        nxt_c = nxt_r.blue;
      end
      default: begin
        cur_c = cur_r.red;
        nxt_c = nxt_r.red;
      end
    endcase
  end

  assign inv_w    = Q_ONE - weight_r;
  assign prod_nxt = 21'(inv_w) * 21'(nxt_c);
  assign prod_cur = 21'(weight_r) * 21'(cur_c);
  assign mix_acc  = prod_nxt + prod_cur;
  assign blend    = mix_acc[Q_BITS +: 8];

  always_comb begin
    state_nxt      = state_r;
    walk_cnt_nxt   = walk_cnt_r;
    found_nxt      = found_r;
    span_hit_nxt   = span_hit_r;
    div_go_nxt     = 1'b0;
    comp_nxt       = comp_r;
    out_strobe_nxt = 1'b0;
    sum_nxt        = sum_r;
    step_nxt       = step_r;
    cur_nxt        = cur_r;
    nxt_nxt        = nxt_r;
    span_nxt       = span_r;
    sdur_nxt       = sdur_r;
    weight_nxt     = weight_r;
    out_col_nxt    = out_col_r;
    out_held_nxt   = out_held_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (in_func == FUNC_EVAL)) begin
          state_nxt    = ST_WALK;
          walk_cnt_nxt = '0;
          found_nxt    = 1'b0;
          span_hit_nxt = 1'b0;
          sum_nxt      = '0;
          step_nxt     = in_time_step;
        end
      end
      ST_WALK: begin
        walk_cnt_nxt = walk_cnt_r + 1'b1;
        sum_nxt      = run_sum[15:0];
        if (hit_span) begin
          found_nxt    = 1'b1;
          span_hit_nxt = 1'b1;
          cur_nxt      = head.colour;
          nxt_nxt      = end_col;
          span_nxt     = span_wide[7:0];
          sdur_nxt     = head.dur;
        end else if (hit_end) begin
          found_nxt = 1'b1;
          cur_nxt   = end_col;
        end
        // keep rotating after a hit so the ring comes home
        if (last) begin
          if (hit_span || span_hit_r) begin
            state_nxt  = ST_DIV;
            div_go_nxt = 1'b1;
          end else begin
            state_nxt      = ST_IDLE;
            out_strobe_nxt = 1'b1;
            out_col_nxt    = hit_end ? end_col : cur_r;
            out_held_nxt   = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          weight_nxt = div_res.weight;
          comp_nxt   = COMP_RED;
          state_nxt  = ST_MIX;
        end
      end
      ST_MIX: begin
        case (comp_r)
          COMP_RED: begin
            out_col_nxt.red = blend;
            comp_nxt        = COMP_GREEN;
          end
          COMP_GREEN: begin
            out_col_nxt.green = blend;
            comp_nxt          = COMP_BLUE;
          end
          COMP_BLUE: begin
            out_col_nxt.blue = blend;
            out_held_nxt     = 1'b0;
            out_strobe_nxt   = 1'b1;
            state_nxt        = ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      walk_cnt_r   <= '0;
      found_r      <= 1'b0;
      span_hit_r   <= 1'b0;
      div_go_r     <= 1'b0;
      comp_r       <= COMP_RED;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      walk_cnt_r   <= walk_cnt_nxt;
      found_r      <= found_nxt;
      span_hit_r   <= span_hit_nxt;
      div_go_r     <= div_go_nxt;
      comp_r       <= comp_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    step_r     <= step_nxt;
    cur_r      <= cur_nxt;
    nxt_r      <= nxt_nxt;
    span_r     <= span_nxt;
    sdur_r     <= sdur_nxt;
    weight_r   <= weight_nxt;
    out_col_r  <= out_col_nxt;
    out_held_r <= out_held_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_color_red   = out_col_r.red;
  assign out_color_green = out_col_r.green;
  assign out_color_blue  = out_col_r.blue;
  assign out_held_at_end = out_held_r;

endmodule

[src/kci_checker.sv]
module kci_checker import kci_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_func,
  input logic out_strobe
);

`include "keyframe_color_interpolator_top_assert.svh"

  // a result only ever closes an evaluate beat
  `KCI_ASSERT_NOW(a_strobe_after_busy, out_strobe, $past(busy), "result without evaluate beat")
  `KCI_ASSERT_NOW(a_strobe_idle, out_strobe, !busy, "busy still high with result")
  `KCI_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe longer than a cycle")
  `KCI_ASSERT_NEXT(a_write_no_busy, start && !busy && (in_func == FUNC_WRITE), !busy,
                   "write beat raised busy")
  `KCI_ASSERT_NEXT(a_eval_busy, start && !busy && (in_func == FUNC_EVAL), busy,
                   "evaluate beat did not raise busy")

endmodule

bind keyframe_color_interpolator_top kci_checker u_kci_checker (.*);
